/* sv/cke_pkg.sv */
// Shared types and constants for the calculator key engine.
// No dependencies; every other file of the block imports this package.
package cke_pkg;

  // Default datapath width of accumulator and entry
  localparam int unsigned VALUE_WIDTH = 64;

  // Entry stops growing once a positive entry exceeds this
  localparam int unsigned ENTRY_LIMIT = 99999999;
  localparam int unsigned DIGIT_BASE  = 10;
  localparam int unsigned PCT_BASE    = 100;
  localparam int unsigned MAX_DIGIT   = 9;

  // Key codes carried on the input transaction
  typedef enum logic [3:0] {
    KEY_DIGIT   = 4'd0,
    KEY_ADD     = 4'd1,
    KEY_SUB     = 4'd2,
    KEY_MUL     = 4'd3,
    KEY_DIV     = 4'd4,
    KEY_EQUALS  = 4'd5,
    KEY_CLEAR   = 4'd6,
    KEY_NEGATE  = 4'd7,
    KEY_PERCENT = 4'd8,
    KEY_DOT     = 4'd9
  } key_e;

  // Pending operator codes
  typedef enum logic [2:0] {
    OPR_NONE = 3'd0,
    OPR_ADD  = 3'd1,
    OPR_SUB  = 3'd2,
    OPR_MUL  = 3'd3,
    OPR_DIV  = 3'd4
  } opr_e;

  // Serial arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_RUN,
    AL_FIX,
    AL_DONE
  } alu_st_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_BUSY,
    ST_OUT
  } ctrl_st_e;

  // Request from the key sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

/* sv/calculator_key_engine_unit.sv */
// Top level of the calculator key engine: stream ports, result register, sequencer and
// serial arithmetic unit. Depends on cke_pkg, cke_alu and cke_ctrl.
//
// One key press per input transaction gives one result transaction with the value shown
// and the error flag. Keys that need arithmetic (digits, operators that fold a pending
// operation, equals, negate, percent) go through the serial arithmetic unit, which
// handles one operand bit per cycle (shift-add multiply, restoring divide, serial add);
// other keys go from decode straight to the result. A new key is accepted once the
// previous one has left the sequencer, while its result may still wait in the output
// register.
module calculator_key_engine_unit #(
  parameter int unsigned VALUE_WIDTH = cke_pkg::VALUE_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] digit, [7:4] zero
  input  logic [3:0]  s_axis_tuser,   // [3:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] display_value
  output logic [0:0]  m_axis_tuser    // [0] error_flag
);
  import cke_pkg::*;

  alu_req_t                 alu_req;
  logic [VALUE_WIDTH-1:0]   alu_a;
  logic [VALUE_WIDTH-1:0]   alu_b;
  logic [VALUE_WIDTH-1:0]   alu_c;
  logic                     alu_done;
  logic [VALUE_WIDTH-1:0]   alu_res;

  logic                     res_valid;
  logic                     res_ready;
  logic [VALUE_WIDTH-1:0]   disp;
  logic                     err;

  logic                     out_valid_q, out_valid_d;
  logic [63:0]              out_data_q, out_data_d;
  logic                     out_err_q, out_err_d;

  cke_ctrl #(
    .W (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (s_axis_tvalid),
    .key_ready_o (s_axis_tready),
    .action_i    (s_axis_tuser),
    .digit_i     (s_axis_tdata[3:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .disp_o      (disp),
    .err_o       (err),
    .alu_req_o   (alu_req),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_c_o     (alu_c),
    .alu_done_i  (alu_done),
    .alu_res_i   (alu_res)
  );

  cke_alu #(
    .W (VALUE_WIDTH)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .c_i    (alu_c),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  // Load the result register when it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = 64'($signed(disp));
      out_err_d   = err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_err_q;

endmodule

/* sv/cke_alu.sv */
// Bit-serial arithmetic unit: add, subtract, multiply-accumulate and signed divide.
// One operand bit is consumed per cycle. Depends on cke_pkg.
module cke_alu #(
  parameter int unsigned W = cke_pkg::VALUE_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cke_pkg::alu_req_t  req_i,
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  logic [W-1:0]       c_i,
  output logic               done_o,
  output logic [W-1:0]       res_o
);
  import cke_pkg::*;

  localparam int unsigned CW = $clog2(W);

  alu_st_e        st_q, st_d;
  alu_op_e        op_q, op_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]   a_q, a_d;
  logic [W-1:0]   b_q, b_d;
  logic [W-1:0]   acc_q, acc_d;
  logic [W:0]     rem_q, rem_d;
  logic           carry_q, carry_d;
  logic           neg_q, neg_d;

  logic [W:0]     r_sh;
  logic [W:0]     r_sub;
  logic           bb;
  logic           sbit;

  // Serial adder bit and restoring-divide trial subtract
  assign bb    = (op_q == ALU_SUB) ? ~b_q[0] : b_q[0];
  assign sbit  = a_q[0] ^ bb ^ carry_q;
  assign r_sh  = {rem_q[W-1:0], a_q[W-1]};
  assign r_sub = r_sh - {1'b0, b_q};

  // Step the datapath
  always_comb begin
    op_d    = op_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    carry_d = carry_q;
    neg_d   = neg_q;
    unique case (st_q)
      AL_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          cnt_d   = CW'(W - 1);
          carry_d = (req_i.op == ALU_SUB);
          rem_d   = '0;
          acc_d   = (req_i.op == ALU_MUL) ? c_i : '0;
          neg_d   = a_i[W-1] ^ b_i[W-1];
          if (req_i.op == ALU_DIV) begin
            a_d = a_i[W-1] ? ('0 - a_i) : a_i;
            b_d = b_i[W-1] ? ('0 - b_i) : b_i;
          end else begin
            a_d = a_i;
            b_d = b_i;
          end
        end
      end
      AL_RUN: begin
        case (op_q)
          ALU_MUL: begin
            if (b_q[0]) begin
              acc_d = acc_q + a_q;
            end
            a_d = {a_q[W-2:0], 1'b0};
            b_d = {1'b0, b_q[W-1:1]};
          end
          ALU_DIV: begin
            a_d   = {a_q[W-2:0], ~r_sub[W]};
            rem_d = r_sub[W] ? r_sh : r_sub;
          end
          default: begin
            acc_d   = {sbit, acc_q[W-1:1]};
            carry_d = (a_q[0] & bb) | (a_q[0] & carry_q) | (bb & carry_q);
            a_d     = {1'b0, a_q[W-1:1]};
            b_d     = {1'b0, b_q[W-1:1]};
          end
        endcase
        cnt_d = cnt_q - 1'b1;
      end
      AL_FIX: begin
        // Apply the quotient sign
        if (op_q == ALU_DIV) begin
          acc_d = neg_q ? ('0 - a_q) : a_q;
        end
      end
      AL_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      AL_IDLE: if (req_i.start) st_d = AL_RUN;
      AL_RUN:  if (cnt_q == '0) st_d = AL_FIX;
      AL_FIX:  st_d = AL_DONE;
      AL_DONE: st_d = AL_IDLE;
      default: st_d = AL_IDLE;
    endcase
  end

  assign done_o = (st_q == AL_DONE);
  assign res_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AL_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    carry_q <= carry_d;
    neg_q   <= neg_d;
  end

endmodule

/* sv/cke_ctrl.sv */
// Key sequencer: holds calculator state, decodes each key and drives the serial unit.
// Depends on cke_pkg; pairs with cke_alu.
module cke_ctrl #(
  parameter int unsigned W = cke_pkg::VALUE_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_valid_i,
  output logic               key_ready_o,
  input  logic [3:0]         action_i,
  input  logic [3:0]         digit_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [W-1:0]       disp_o,
  output logic               err_o,
  output cke_pkg::alu_req_t  alu_req_o,
  output logic [W-1:0]       alu_a_o,
  output logic [W-1:0]       alu_b_o,
  output logic [W-1:0]       alu_c_o,
  input  logic               alu_done_i,
  input  logic [W-1:0]       alu_res_i
);
  import cke_pkg::*;

  ctrl_st_e      st_q, st_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  ent_q, ent_d;
  opr_e          pop_q, pop_d;
  logic          entering_q, entering_d;
  logic          av_q, av_d;
  logic          err_q, err_d;
  key_e          key_q, key_d;
  logic [3:0]    dig_q, dig_d;
  logic          wb_acc_q, wb_acc_d;
  logic          wb_ent_q, wb_ent_d;

  logic          alu_go;
  alu_op_e       alu_op;
  logic          do_comb;
  logic [W-1:0]  e0;

  // Entry as seen by a digit key: a fresh entry starts from zero
  assign e0 = entering_q ? ent_q : '0;

  // Decode the key, update state, write back serial results
  always_comb begin
    acc_d      = acc_q;
    ent_d      = ent_q;
    pop_d      = pop_q;
    entering_d = entering_q;
    av_d       = av_q;
    err_d      = err_q;
    key_d      = key_q;
    dig_d      = dig_q;
    wb_acc_d   = wb_acc_q;
    wb_ent_d   = wb_ent_q;
    alu_go     = 1'b0;
    alu_op     = ALU_ADD;
    alu_a_o    = acc_q;
    alu_b_o    = ent_q;
    alu_c_o    = '0;
    do_comb    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (key_valid_i) begin
          key_d = key_e'(action_i);
          dig_d = digit_i;
        end
      end
      ST_DECODE: begin
        wb_acc_d = 1'b0;
        wb_ent_d = 1'b0;
        if (key_q == KEY_CLEAR) begin
          acc_d      = '0;
          ent_d      = '0;
          pop_d      = OPR_NONE;
          entering_d = 1'b0;
          av_d       = 1'b0;
          err_d      = 1'b0;
        end else if (!err_q) begin
          unique case (key_q) inside
            KEY_DIGIT: begin
              if (dig_q <= 4'(MAX_DIGIT)) begin
                entering_d = 1'b1;
                ent_d      = e0;
                if (e0[W-1] || (e0 <= W'(ENTRY_LIMIT))) begin
                  alu_go   = 1'b1;
                  alu_op   = ALU_MUL;
                  alu_a_o  = e0;
                  alu_b_o  = W'(DIGIT_BASE);
                  alu_c_o  = W'(dig_q);
                  wb_ent_d = 1'b1;
                end
              end
            end
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
              if (entering_q) begin
                do_comb    = 1'b1;
                entering_d = 1'b0;
              end else if (!av_q) begin
                acc_d = ent_q;
                av_d  = 1'b1;
              end
              pop_d = opr_e'(key_q[2:0]);
              ent_d = '0;
            end
            KEY_EQUALS: begin
              if (pop_q != OPR_NONE) begin
                do_comb = 1'b1;
              end else if (entering_q) begin
                acc_d = ent_q;
                av_d  = 1'b1;
              end
              pop_d      = OPR_NONE;
              entering_d = 1'b0;
            end
            KEY_NEGATE, KEY_PERCENT: begin
              alu_go  = 1'b1;
              alu_op  = (key_q == KEY_NEGATE) ? ALU_SUB : ALU_DIV;
              alu_a_o = (key_q == KEY_NEGATE) ? '0 : (entering_q ? ent_q : acc_q);
              alu_b_o = (key_q == KEY_NEGATE) ? (entering_q ? ent_q : acc_q)
                                              : W'(PCT_BASE);
              wb_ent_d = 1'b1;
              wb_acc_d = !entering_q;
            end
            default: begin
            end
          endcase

          // Fold the entry into the accumulator
          if (do_comb) begin
            if (!av_q) begin
              acc_d = ent_q;
              av_d  = 1'b1;
            end else begin
              unique case (pop_q)
                OPR_ADD: begin
                  alu_go   = 1'b1;
                  alu_op   = ALU_ADD;
                  wb_acc_d = 1'b1;
                end
                OPR_SUB: begin
                  alu_go   = 1'b1;
                  alu_op   = ALU_SUB;
                  wb_acc_d = 1'b1;
                end
                OPR_MUL: begin
                  alu_go   = 1'b1;
                  alu_op   = ALU_MUL;
                  wb_acc_d = 1'b1;
                end
                OPR_DIV: begin
                  if (ent_q == '0) begin
                    err_d = 1'b1;
                  end else begin
                    alu_go   = 1'b1;
                    alu_op   = ALU_DIV;
                    wb_acc_d = 1'b1;
                  end
                end
                default: begin
                  acc_d = ent_q;
                end
              endcase
            end
          end

          // Equals shows the accumulator as the new entry
          if (key_q == KEY_EQUALS) begin
            ent_d    = acc_d;
            wb_ent_d = alu_go;
          end
        end
      end
      ST_BUSY: begin
        if (alu_done_i) begin
          if (wb_acc_q) begin
            acc_d = alu_res_i;
          end
          if (wb_ent_q) begin
            ent_d = alu_res_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (key_valid_i) st_d = ST_DECODE;
      ST_DECODE: st_d = alu_go ? ST_BUSY : ST_OUT;
      ST_BUSY:   if (alu_done_i) st_d = ST_OUT;
      ST_OUT:    if (res_ready_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    key_ready_o     = (st_q == ST_IDLE);
    res_valid_o     = (st_q == ST_OUT);
    alu_req_o.start = alu_go;
    alu_req_o.op    = alu_op;
    err_o           = err_q;
    if (err_q) begin
      disp_o = '0;
    end else if (entering_q || !av_q) begin
      disp_o = ent_q;
    end else begin
      disp_o = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      acc_q      <= '0;
      ent_q      <= '0;
      pop_q      <= OPR_NONE;
      entering_q <= 1'b0;
      av_q       <= 1'b0;
      err_q      <= 1'b0;
      wb_acc_q   <= 1'b0;
      wb_ent_q   <= 1'b0;
    end else begin
      st_q       <= st_d;
      acc_q      <= acc_d;
      ent_q      <= ent_d;
      pop_q      <= pop_d;
      entering_q <= entering_d;
      av_q       <= av_d;
      err_q      <= err_d;
      wb_acc_q   <= wb_acc_d;
      wb_ent_q   <= wb_ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    dig_q <= dig_d;
  end

endmodule

/* tb/calculator_key_engine_unit_tb.sv */
// Self-checking testbench for calculator_key_engine_unit: drives key presses on the input
// stream, predicts the shown value and error flag and checks every result transaction.
// Depends on cke_pkg and the calculator_key_engine_unit RTL.
`timescale 1ns / 1ps

module calculator_key_engine_unit_tb;
  import cke_pkg::*;

  localparam int unsigned NUM_KEYS     = 1800;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned MAX_REPORTS  = 10;

  // One expected result transaction
  typedef struct packed {
    logic [63:0] value;
    logic        err;
  } shown_t;

  // Calculator state tracker and store of expected shown values
  class key_scoreboard;
    logic [63:0] acc;
    logic [63:0] entry;
    opr_e        pend;
    bit          entering;
    bit          acc_ok;
    bit          err;
    shown_t      shown_q[$];
    int unsigned bad_count;

    function new();
      clear_state();
      bad_count = 0;
    endfunction

    function void clear_state();
      acc      = '0;
      entry    = '0;
      pend     = OPR_NONE;
      entering = 1'b0;
      acc_ok   = 1'b0;
      err      = 1'b0;
    endfunction

    // Signed quotient truncated toward zero; most negative over minus one wraps
    function logic [63:0] trunc_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      un = num[63] ? -num : num;
      ud = den[63] ? -den : den;
      q  = un / ud;
      return (num[63] ^ den[63]) ? -q : q;
    endfunction

    // Apply the pending operator to accumulator and entry
    function void fold_pending();
      if (!acc_ok) begin
        acc    = entry;
        acc_ok = 1'b1;
        return;
      end
      case (pend)
        OPR_ADD: acc = acc + entry;
        OPR_SUB: acc = acc - entry;
        OPR_MUL: acc = acc * entry;
        OPR_DIV: begin
          if (entry == '0) err = 1'b1;
          else acc = trunc_div(acc, entry);
        end
        default: acc = entry;
      endcase
    endfunction

    function void press_operator(opr_e op);
      if (entering) begin
        fold_pending();
        entering = 1'b0;
      end else if (!acc_ok) begin
        acc    = entry;
        acc_ok = 1'b1;
      end
      pend  = op;
      entry = '0;
    endfunction

    // Advance the state by one accepted key and queue the shown value;
    // return 0 when the key has no effect at all
    function bit note_key(logic [3:0] action, logic [3:0] digit);
      bit     effective;
      shown_t want;
      effective = 1'b1;
      if (action == KEY_CLEAR) begin
        clear_state();
      end else if (err) begin
        effective = 1'b0;
      end else begin
        case (action)
          KEY_DIGIT: begin
            if (digit > MAX_DIGIT) begin
              effective = 1'b0;
            end else begin
              if (!entering) begin
                entry    = '0;
                entering = 1'b1;
              end
              // positive entries stop growing past the limit, negative ones wrap
              if (entry[63] || entry <= ENTRY_LIMIT) entry = entry * DIGIT_BASE + digit;
            end
          end
          KEY_ADD: press_operator(OPR_ADD);
          KEY_SUB: press_operator(OPR_SUB);
          KEY_MUL: press_operator(OPR_MUL);
          KEY_DIV: press_operator(OPR_DIV);
          KEY_EQUALS: begin
            if (pend != OPR_NONE) begin
              fold_pending();
            end else if (entering) begin
              acc    = entry;
              acc_ok = 1'b1;
            end
            pend     = OPR_NONE;
            entering = 1'b0;
            entry    = acc;
          end
          KEY_NEGATE: begin
            if (entering) begin
              entry = -entry;
            end else begin
              acc   = -acc;
              entry = acc;
            end
          end
          KEY_PERCENT: begin
            if (entering) begin
              entry = trunc_div(entry, 64'(PCT_BASE));
            end else begin
              acc   = trunc_div(acc, 64'(PCT_BASE));
              entry = acc;
            end
          end
          // dot and unused codes change nothing
          default: effective = 1'b0;
        endcase
      end
      want.err   = err;
      want.value = err ? '0 : (entering ? entry : (acc_ok ? acc : entry));
      shown_q.push_back(want);
      return effective;
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic [63:0] value, logic err_o);
      shown_t want;
      if (shown_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("unexpected result: value %0d err %0b", $signed(value), err_o);
        return;
      end
      want = shown_q.pop_front();
      if (value !== want.value || err_o !== want.err) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS)
          $display("result mismatch: expected value %0d err %0b, got value %0d err %0b",
                   $signed(want.value), want.err, $signed(value), err_o);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] digit, [7:4] zero
  logic [3:0]  s_axis_tuser = '0;   // [3:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] display_value
  logic [0:0]  m_axis_tuser;        // [0] error_flag

  key_scoreboard sb = new();
  int unsigned   effective_keys = 0;
  int unsigned   burst_left = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   ready_mode = 0;
  int unsigned   mode_left = 0;

  calculator_key_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Send one key press in bursts with random gaps; return after its transaction
  task automatic send_key(logic [3:0] action, logic [3:0] digit);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(7, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {4'b0000, digit};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (sb.note_key(action, digit)) effective_keys++;
  endtask

  task automatic type_number(longint unsigned number);
    logic [3:0]      digs[$];
    longint unsigned rest;
    rest = number;
    do begin
      digs.push_front(4'(rest % DIGIT_BASE));
      rest = rest / DIGIT_BASE;
    end while (rest != 0);
    foreach (digs[i]) send_key(KEY_DIGIT, digs[i]);
  endtask

  // Random operand: mostly short, some past the entry limit, a few long negative ones
  task automatic type_operand();
    int unsigned len;
    int unsigned pick;
    bit          long_neg;
    pick     = $urandom_range(0, 99);
    long_neg = (pick < 2);
    if (long_neg) len = $urandom_range(18, 22);
    else if (pick < 65) len = $urandom_range(1, 3);
    else if (pick < 88) len = $urandom_range(4, 8);
    else len = $urandom_range(9, 12);
    for (int i = 0; i < len; i++) begin
      send_key(KEY_DIGIT, 4'($urandom_range(0, 9)));
      if ((long_neg && i == 0) || $urandom_range(0, 39) == 0) send_key(KEY_NEGATE, 4'd0);
      if ($urandom_range(0, 59) == 0) send_key(KEY_DOT, 4'd0);
    end
    case ($urandom_range(0, 19))
      0: send_key(KEY_NEGATE, 4'd0);
      1: send_key(KEY_PERCENT, 4'd0);
      default: ;
    endcase
  endtask

  // Well-formed expression with random operands and operators
  task automatic key_expression();
    int unsigned terms;
    if (sb.err ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 4) == 0))
      send_key(KEY_CLEAR, 4'd0);
    type_operand();
    terms = $urandom_range(1, 4);
    repeat (terms) begin
      send_key(4'(KEY_ADD + $urandom_range(0, 3)), 4'd0);
      if ($urandom_range(0, 19) != 0) type_operand();
    end
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        send_key(KEY_EQUALS, 4'd0);
        send_key(KEY_EQUALS, 4'd0);
      end
      2: begin
        send_key(KEY_EQUALS, 4'd0);
        send_key($urandom_range(0, 1) ? KEY_NEGATE : KEY_PERCENT, 4'd0);
      end
      default: send_key(KEY_EQUALS, 4'd0);
    endcase
  endtask

  // Raw noise over every action and digit code
  task automatic key_noise();
    repeat ($urandom_range(1, 6)) send_key(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  // Stimulus and end of run
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2^26 * 2^26 * 2^11 wraps to the most negative value, then divide by minus one
    type_number(67108864);
    send_key(KEY_MUL, 4'd0);
    type_number(67108864);
    send_key(KEY_MUL, 4'd0);
    type_number(2048);
    send_key(KEY_DIV, 4'd0);
    type_number(1);
    send_key(KEY_NEGATE, 4'd0);
    send_key(KEY_EQUALS, 4'd0);
    // divide by zero latches the error until clear
    send_key(KEY_DIV, 4'd0);
    type_number(0);
    send_key(KEY_EQUALS, 4'd0);
    send_key(KEY_CLEAR, 4'd0);

    while (effective_keys < NUM_KEYS) begin
      if ($urandom_range(0, 99) < 12) key_noise();
      else key_expression();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.shown_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.bad_count == 0 && sb.shown_q.size() == 0) begin
      $display("PASS calculator_key_engine_unit");
    end else begin
      $display("FAIL calculator_key_engine_unit");
    end
    $finish;
  end

  // Check result transactions and stall the output on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Stop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL calculator_key_engine_unit");
      $finish;
    end
  end

endmodule
